[design/mbde_pkg.sv]
// ----------------------------------------------------------------------------
// mbde_pkg
// Shared types and constants of the monochrome bitmap draw engine.
// ----------------------------------------------------------------------------
package mbde_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int REQ_W   = 3;   // command code
    localparam int COORD_W = 15;  // input coordinates
    localparam int RAD_W   = 14;  // radius
    localparam int DATA_W  = 8;   // pixels per read
    localparam int CFG_W   = 10;  // page size registers
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // internal coordinate width: center +- radius fits
    localparam int CW = 18;
    // magnitude of a line delta
    localparam int DW = 16;

    localparam int QDEPTH = 2;

    localparam logic REG_PAGE_WIDTH  = 1'b0;
    localparam logic REG_PAGE_HEIGHT = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_POINT  = 3'd1,
        CMD_RECT   = 3'd2,
        CMD_LINE   = 3'd3,
        CMD_DISC   = 3'd4,
        CMD_CIRCLE = 3'd5,
        CMD_READ   = 3'd6,
        CMD_NOP    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        OP_SET,
        OP_CLEAR,
        OP_READ
    } t_op_kind;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_POINT,
        ST_RECT_SETUP,
        ST_RECT,
        ST_LINE,
        ST_DISC_ADJ,
        ST_SPAN_SETUP,
        ST_SPAN,
        ST_DISC_NEXT,
        ST_OUT,
        ST_READ,
        ST_DRAIN
    } t_back_state;

    // classified command, as queued between front and back
    typedef struct packed {
        t_cmd                    cmd;
        logic signed [CW-1:0]    xa;
        logic signed [CW-1:0]    ya;
        logic signed [CW-1:0]    xb;
        logic signed [CW-1:0]    yb;
        logic [RAD_W-1:0]        radius;
        logic [DW-1:0]           dmaj_abs;
        logic [DW-1:0]           dmin_abs;
        logic                    ymajor;
        logic                    maj_neg;
        logic                    min_neg;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_queue_ctl;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

[design/mbde_ram.sv]
// ----------------------------------------------------------------------------
// mbde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbde_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/mbde_front.sv]
// ----------------------------------------------------------------------------
// mbde_front
// Accepts commands, classifies them (line deltas, major axis) and queues them.
// ----------------------------------------------------------------------------
module mbde_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic [mbde_pkg::REQ_W-1:0]             i_req_type,
    input  logic signed [mbde_pkg::COORD_W-1:0]    i_x_a,
    input  logic signed [mbde_pkg::COORD_W-1:0]    i_y_a,
    input  logic signed [mbde_pkg::COORD_W-1:0]    i_x_b,
    input  logic signed [mbde_pkg::COORD_W-1:0]    i_y_b,
    input  logic [mbde_pkg::RAD_W-1:0]             i_radius,
    input  mbde_pkg::t_back_status                 i_status,
    input  logic                                   i_pop,
    output mbde_pkg::t_queue_ctl                   o_ctl,
    output mbde_pkg::t_entry                       o_head
);

    localparam int CW  = mbde_pkg::CW;
    localparam int DW  = mbde_pkg::DW;
    localparam int QD  = mbde_pkg::QDEPTH;
    localparam int QPW = $clog2(QD);

    mbde_pkg::t_entry r_q [QD];
    logic [QPW-1:0]   r_wptr;
    logic [QPW-1:0]   r_rptr;
    logic [QPW:0]     r_count;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
    logic                 ymajor;
    mbde_pkg::t_entry     entry;

    assign full   = (r_count == (QPW+1)'(QD));
    assign empty  = (r_count == '0);
    assign o_busy = full || i_status.init_busy;
    assign accept = i_start && !o_busy;

    // classification
    always_comb begin
        dx     = CW'(i_x_b) - CW'(i_x_a);
        dy     = CW'(i_y_b) - CW'(i_y_a);
        adx    = dx[CW-1] ? DW'(-dx) : DW'(dx);
        ady    = dy[CW-1] ? DW'(-dy) : DW'(dy);
        ymajor = (adx < ady);

        entry.cmd      = mbde_pkg::t_cmd'(i_req_type);
        entry.xa       = CW'(i_x_a);
        entry.ya       = CW'(i_y_a);
        entry.xb       = CW'(i_x_b);
        entry.yb       = CW'(i_y_b);
        entry.radius   = i_radius;
        entry.ymajor   = ymajor;
        entry.dmaj_abs = ymajor ? ady : adx;
        entry.dmin_abs = ymajor ? adx : ady;
        entry.maj_neg  = ymajor ? dy[CW-1] : dx[CW-1];
        entry.min_neg  = ymajor ? dx[CW-1] : dy[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wptr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop && !empty) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (QPW+1)'(accept) - (QPW+1)'(i_pop && !empty);
        end
    end

    assign o_ctl.valid = !empty;
    assign o_ctl.pop   = i_pop && !empty;
    assign o_head      = r_q[r_rptr];

endmodule

[design/mbde_back.sv]
// ----------------------------------------------------------------------------
// mbde_back
// Walks each command pixel by pixel and applies it to the page store through
// a three stage pixel pipeline (address multiply, address add, RAM access).
// ----------------------------------------------------------------------------
module mbde_back #(
    parameter int MAX_WIDTH  = mbde_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mbde_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_eff_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     i_eff_h,
    input  mbde_pkg::t_queue_ctl                i_ctl,
    input  mbde_pkg::t_entry                    i_head,
    output logic                                o_pop,
    output mbde_pkg::t_back_status              o_status,
    output logic                                o_result_valid,
    output logic [mbde_pkg::DATA_W-1:0]         o_read_data
);

    localparam int CW    = mbde_pkg::CW;
    localparam int DW    = mbde_pkg::DW;
    localparam int RW    = mbde_pkg::RAD_W;
    localparam int DTW   = mbde_pkg::DATA_W;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [CW-1:0] S_ONE = CW'(1);

    // walker state
    mbde_pkg::t_back_state r_state, n_state;
    mbde_pkg::t_entry      r_cmd, n_cmd;
    logic signed [CW-1:0]  r_x, n_x;
    logic signed [CW-1:0]  r_y, n_y;
    logic signed [CW-1:0]  r_x_start, n_x_start;
    logic signed [CW-1:0]  r_x_end, n_x_end;
    logic signed [CW-1:0]  r_y_end, n_y_end;
    logic signed [CW-1:0]  r_err, n_err;
    logic [AW-1:0]         r_cnt, n_cnt;
    logic [AW:0]           r_area;
    logic [DW-1:0]         r_t, n_t;
    logic [DW-1:0]         r_q, n_q;
    logic [DW:0]           r_rem, n_rem;
    logic [RW-1:0]         r_xm, n_xm;
    logic [RW-1:0]         r_dy, n_dy;
    logic                  r_phase, n_phase;
    logic [2:0]            r_sub, n_sub;
    logic [DTW-1:0]        r_acc, n_acc;

    // pixel op issued by the walker
    logic                  r_op_valid, n_op_valid;
    mbde_pkg::t_op_kind    r_op_kind, n_op_kind;
    logic                  r_op_lin, n_op_lin;
    logic signed [CW-1:0]  r_op_x, n_op_x;
    logic signed [CW-1:0]  r_op_y, n_op_y;
    logic [AW-1:0]         r_op_addr, n_op_addr;

    // pipeline stages
    logic                  r_pa_valid;
    mbde_pkg::t_op_kind    r_pa_kind;
    logic                  r_pa_in;
    logic [AW-1:0]         r_pa_prod;
    logic [AW-1:0]         r_pa_xi;
    logic                  r_pb_valid;
    mbde_pkg::t_op_kind    r_pb_kind;
    logic                  r_pb_in;
    logic [AW-1:0]         r_pb_addr;
    logic                  r_pc_valid;
    logic                  r_pc_in;
    logic                  ram_rdata;

    logic                  r_res_valid, n_res_valid;
    logic [DTW-1:0]        r_res_data, n_res_data;

    // shared conditions
    logic signed [CW-1:0]  ws, hs;
    logic signed [CW-1:0]  rx1, rx2, ry1, ry2;
    logic                  rect_ok;
    logic signed [CW-1:0]  sp_lo, sp_hi;
    logic                  row_in, span_ok;
    logic signed [CW-1:0]  xs, ys;
    logic signed [CW-1:0]  off, tt;
    logic [DW:0]           rem_sum;
    logic                  op_in;
    logic                  pipe_empty;
    logic                  pop;

    assign ws = $signed(CW'(i_eff_w));
    assign hs = $signed(CW'(i_eff_h));

    always_comb begin
        rx1     = r_cmd.xa[CW-1] ? '0 : r_cmd.xa;
        ry1     = r_cmd.ya[CW-1] ? '0 : r_cmd.ya;
        rx2     = (r_cmd.xb > ws) ? ws : r_cmd.xb;
        ry2     = (r_cmd.yb > hs) ? hs : r_cmd.yb;
        rect_ok = (rx1 < rx2) && (ry1 < ry2);

        sp_lo   = r_x_start[CW-1] ? '0 : r_x_start;
        sp_hi   = (r_x_end > ws - S_ONE) ? ws - S_ONE : r_x_end;
        row_in  = !r_y[CW-1] && ($unsigned(r_y) < CW'(i_eff_h));
        span_ok = row_in && (sp_lo <= sp_hi);

        xs      = $signed(CW'(r_xm));
        ys      = $signed(CW'(r_dy));
        off     = r_cmd.min_neg ? -$signed(CW'(r_q)) : $signed(CW'(r_q));
        tt      = r_cmd.maj_neg ? -$signed(CW'(r_t)) : $signed(CW'(r_t));
        rem_sum = r_rem + (DW+1)'(r_cmd.dmin_abs);

        pipe_empty = !r_op_valid && !r_pa_valid && !r_pb_valid && !r_pc_valid;
    end

    assign pop = (r_state == mbde_pkg::ST_IDLE) && i_ctl.valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbde_pkg::ST_INIT: begin
                if (r_cnt == AW'(DEPTH - 1)) n_state = mbde_pkg::ST_IDLE;
            end
            mbde_pkg::ST_IDLE: begin
                if (i_ctl.valid) begin
                    unique case (i_head.cmd)
                        mbde_pkg::CMD_CLEAR:  n_state = mbde_pkg::ST_CLEAR;
                        mbde_pkg::CMD_POINT:  n_state = mbde_pkg::ST_POINT;
                        mbde_pkg::CMD_RECT:   n_state = mbde_pkg::ST_RECT_SETUP;
                        mbde_pkg::CMD_LINE:   n_state = mbde_pkg::ST_LINE;
                        mbde_pkg::CMD_DISC:   n_state = mbde_pkg::ST_DISC_ADJ;
                        mbde_pkg::CMD_CIRCLE: n_state = mbde_pkg::ST_OUT;
                        mbde_pkg::CMD_READ:   n_state = mbde_pkg::ST_READ;
                        default:              n_state = mbde_pkg::ST_DRAIN;
                    endcase
                end
            end
            mbde_pkg::ST_CLEAR: begin
                if (r_cnt == AW'(r_area - 1'b1)) n_state = mbde_pkg::ST_DRAIN;
            end
            mbde_pkg::ST_POINT: n_state = mbde_pkg::ST_DRAIN;
            mbde_pkg::ST_RECT_SETUP: begin
                n_state = rect_ok ? mbde_pkg::ST_RECT : mbde_pkg::ST_DRAIN;
            end
            mbde_pkg::ST_RECT: begin
                if (r_x == r_x_end && r_y == r_y_end) n_state = mbde_pkg::ST_DRAIN;
            end
            mbde_pkg::ST_LINE: begin
                if (r_t == r_cmd.dmaj_abs) n_state = mbde_pkg::ST_DRAIN;
            end
            mbde_pkg::ST_DISC_ADJ: begin
                if (!(r_err > 0)) n_state = mbde_pkg::ST_SPAN_SETUP;
            end
            mbde_pkg::ST_SPAN_SETUP: begin
                n_state = span_ok ? mbde_pkg::ST_SPAN : mbde_pkg::ST_DISC_NEXT;
            end
            mbde_pkg::ST_SPAN: begin
                if (r_x == r_x_end) n_state = mbde_pkg::ST_DISC_NEXT;
            end
            mbde_pkg::ST_DISC_NEXT: begin
                if (!r_phase)                  n_state = mbde_pkg::ST_SPAN_SETUP;
                else if (r_dy == r_cmd.radius) n_state = mbde_pkg::ST_DRAIN;
                else                           n_state = mbde_pkg::ST_DISC_ADJ;
            end
            mbde_pkg::ST_OUT: begin
                if (r_sub[1:0] == 2'd3 && !r_err[CW-1] && r_dy == '0) begin
                    n_state = mbde_pkg::ST_DRAIN;
                end
            end
            mbde_pkg::ST_READ: begin
                if (r_sub == 3'd7) n_state = mbde_pkg::ST_DRAIN;
            end
            mbde_pkg::ST_DRAIN: begin
                if (pipe_empty) n_state = mbde_pkg::ST_IDLE;
            end
            default: n_state = mbde_pkg::ST_IDLE;
        endcase
    end

    // walker datapath and pixel ops
    always_comb begin
        n_cmd       = r_cmd;
        n_x         = r_x;
        n_y         = r_y;
        n_x_start   = r_x_start;
        n_x_end     = r_x_end;
        n_y_end     = r_y_end;
        n_err       = r_err;
        n_cnt       = r_cnt;
        n_t         = r_t;
        n_q         = r_q;
        n_rem       = r_rem;
        n_xm        = r_xm;
        n_dy        = r_dy;
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_op_valid  = 1'b0;
        n_op_kind   = mbde_pkg::OP_SET;
        n_op_lin    = 1'b0;
        n_op_x      = r_x;
        n_op_y      = r_y;
        n_op_addr   = r_cnt;
        n_res_valid = 1'b0;
        n_res_data  = r_res_data;

        unique case (r_state)
            mbde_pkg::ST_INIT, mbde_pkg::ST_CLEAR: begin
                n_op_valid = 1'b1;
                n_op_kind  = mbde_pkg::OP_CLEAR;
                n_op_lin   = 1'b1;
                n_cnt      = r_cnt + 1'b1;
            end
            mbde_pkg::ST_IDLE: begin
                if (i_ctl.valid) begin
                    n_cmd   = i_head;
                    n_cnt   = '0;
                    n_t     = '0;
                    n_q     = '0;
                    n_rem   = '0;
                    n_sub   = '0;
                    n_phase = 1'b0;
                    n_err   = '0;
                    if (i_head.cmd == mbde_pkg::CMD_CIRCLE) begin
                        n_xm = '0;
                        n_dy = i_head.radius;
                    end else begin
                        n_xm = i_head.radius;
                        n_dy = '0;
                    end
                end
            end
            mbde_pkg::ST_POINT: begin
                n_op_valid = 1'b1;
                n_op_x     = r_cmd.xa;
                n_op_y     = r_cmd.ya;
            end
            mbde_pkg::ST_RECT_SETUP: begin
                n_x       = rx1;
                n_x_start = rx1;
                n_x_end   = rx2 - S_ONE;
                n_y       = ry1;
                n_y_end   = ry2 - S_ONE;
            end
            mbde_pkg::ST_RECT: begin
                n_op_valid = 1'b1;
                if (r_x == r_x_end) begin
                    n_x = r_x_start;
                    n_y = r_y + S_ONE;
                end else begin
                    n_x = r_x + S_ONE;
                end
            end
            mbde_pkg::ST_LINE: begin
                n_op_valid = 1'b1;
                n_op_x     = r_cmd.xa + (r_cmd.ymajor ? off : tt);
                n_op_y     = r_cmd.ya + (r_cmd.ymajor ? tt : off);
                n_t        = r_t + 1'b1;
                // running quotient and remainder of t*|dmin| / |dmaj|
                if (rem_sum >= (DW+1)'(r_cmd.dmaj_abs)) begin
                    n_rem = rem_sum - (DW+1)'(r_cmd.dmaj_abs);
                    n_q   = r_q + 1'b1;
                end else begin
                    n_rem = rem_sum;
                end
            end
            mbde_pkg::ST_DISC_ADJ: begin
                if (r_err > 0) begin
                    n_err = r_err - (xs <<< 1) + S_ONE;
                    n_xm  = r_xm - 1'b1;
                end else begin
                    n_y       = r_cmd.ya - ys;
                    n_x_start = r_cmd.xa - xs;
                    n_x_end   = r_cmd.xa + xs;
                    n_phase   = 1'b0;
                end
            end
            mbde_pkg::ST_SPAN_SETUP: begin
                n_x     = sp_lo;
                n_x_end = sp_hi;
            end
            mbde_pkg::ST_SPAN: begin
                n_op_valid = 1'b1;
                n_x        = r_x + S_ONE;
            end
            mbde_pkg::ST_DISC_NEXT: begin
                if (!r_phase) begin
                    n_phase   = 1'b1;
                    n_y       = r_cmd.ya + ys;
                    n_x_start = r_cmd.xa - xs;
                    n_x_end   = r_cmd.xa + xs;
                end else begin
                    n_phase = 1'b0;
                    n_dy    = r_dy + 1'b1;
                    n_err   = r_err + (ys <<< 1) + S_ONE;
                end
            end
            mbde_pkg::ST_OUT: begin
                n_op_valid = 1'b1;
                n_op_x     = r_sub[0] ? r_cmd.xa - xs : r_cmd.xa + xs;
                n_op_y     = r_sub[1] ? r_cmd.ya + ys : r_cmd.ya - ys;
                if (r_sub[1:0] == 2'd3) begin
                    n_sub = '0;
                    if (r_err[CW-1]) begin
                        n_xm  = r_xm + 1'b1;
                        n_err = r_err + (xs <<< 1) + S_ONE;
                    end else if (r_dy != '0) begin
                        n_dy  = r_dy - 1'b1;
                        n_err = r_err - (ys <<< 1) + S_ONE;
                    end
                end else begin
                    n_sub = r_sub + 1'b1;
                end
            end
            mbde_pkg::ST_READ: begin
                n_op_valid = 1'b1;
                n_op_kind  = mbde_pkg::OP_READ;
                n_op_x     = r_cmd.xa + $signed(CW'(r_sub));
                n_op_y     = r_cmd.ya;
                n_sub      = r_sub + 1'b1;
            end
            mbde_pkg::ST_DRAIN: begin
                if (pipe_empty) begin
                    n_res_valid = 1'b1;
                    n_res_data  = r_acc;
                end
            end
            default: begin
            end
        endcase

        if (pop) begin
            n_acc = '0;
        end else if (r_pc_valid) begin
            n_acc = {r_acc[DTW-2:0], r_pc_in & ram_rdata};
        end else begin
            n_acc = r_acc;
        end
    end

    // clip test for the issued op
    assign op_in = r_op_lin ||
                   (!r_op_x[CW-1] && ($unsigned(r_op_x) < CW'(i_eff_w)) &&
                    !r_op_y[CW-1] && ($unsigned(r_op_y) < CW'(i_eff_h)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbde_pkg::ST_INIT;
            r_cnt       <= '0;
            r_op_valid  <= 1'b0;
            r_pa_valid  <= 1'b0;
            r_pb_valid  <= 1'b0;
            r_pc_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_op_valid  <= n_op_valid;
            r_pa_valid  <= r_op_valid;
            r_pb_valid  <= r_pa_valid;
            r_pc_valid  <= r_pb_valid && (r_pb_kind == mbde_pkg::OP_READ);
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_x        <= n_x;
        r_y        <= n_y;
        r_x_start  <= n_x_start;
        r_x_end    <= n_x_end;
        r_y_end    <= n_y_end;
        r_err      <= n_err;
        r_t        <= n_t;
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_xm       <= n_xm;
        r_dy       <= n_dy;
        r_phase    <= n_phase;
        r_sub      <= n_sub;
        r_acc      <= n_acc;
        r_res_data <= n_res_data;
        r_area     <= (AW+1)'((AW+1)'(i_eff_w) * (AW+1)'(i_eff_h));

        r_op_kind  <= n_op_kind;
        r_op_lin   <= n_op_lin;
        r_op_x     <= n_op_x;
        r_op_y     <= n_op_y;
        r_op_addr  <= n_op_addr;

        // stage a: row offset
        r_pa_kind  <= r_op_kind;
        r_pa_in    <= op_in;
        r_pa_prod  <= r_op_lin ? r_op_addr
                               : AW'(AW'(r_op_y[YW-1:0]) * AW'(i_eff_w));
        r_pa_xi    <= r_op_lin ? '0 : AW'(r_op_x[XW-1:0]);

        // stage b: full address, RAM access
        r_pb_kind  <= r_pa_kind;
        r_pb_in    <= r_pa_in;
        r_pb_addr  <= AW'(r_pa_prod + r_pa_xi);

        // stage c: read data returns
        r_pc_in    <= r_pb_in;
    end

    mbde_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_pb_valid && r_pb_in && (r_pb_kind != mbde_pkg::OP_READ)),
        .i_waddr (r_pb_addr),
        .i_wdata (r_pb_kind == mbde_pkg::OP_SET),
        .i_raddr (r_pb_addr),
        .o_rdata (ram_rdata)
    );

    assign o_pop              = pop;
    assign o_status.init_busy = (r_state == mbde_pkg::ST_INIT);
    assign o_result_valid     = r_res_valid;
    assign o_read_data        = r_res_data;

endmodule

[design/monochrome_bitmap_draw_engine_core.sv]
// ----------------------------------------------------------------------------
// monochrome_bitmap_draw_engine_core
// One-bit-per-pixel drawing engine: clear, point, rectangle, line, disc,
// circle outline and eight-pixel read on a page held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: an item is taken on a clock edge with start high and
//    busy low. Fields: i_req_type, i_x_a, i_y_a, i_x_b, i_y_b, i_radius.
//  - Result channel: every item yields one result, o_result_valid high for
//    one cycle with o_read_data (pixels of a read, else 0). Results come in
//    item order; the receiver cannot stall, so none is ever held back.
//  - Up to two items queue up ahead of the drawing unit; busy rises when
//    the queue is full.
//  - The pixel walker issues one pixel per cycle while drawing into the page
//    RAM, with setup steps before and a pipeline drain after. Pixels per item:
//    clear w*h, point 1, rectangle clipped area, line |major delta|+1,
//    disc its clipped spans, outline four per step around the ring,
//    read 8, unused code 0.
//  - Reset: page size returns to 512 x 512 and a clearing pass writes all
//    MAX_WIDTH*MAX_HEIGHT pixels with busy high.
//  - APB: page_width at 0x0, page_height at 0x4; write only while idle.
// ----------------------------------------------------------------------------
module monochrome_bitmap_draw_engine_core #(
    parameter int MAX_WIDTH  = mbde_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mbde_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [mbde_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [mbde_pkg::COORD_W-1:0] i_x_a,
    input  logic signed [mbde_pkg::COORD_W-1:0] i_y_a,
    input  logic signed [mbde_pkg::COORD_W-1:0] i_x_b,
    input  logic signed [mbde_pkg::COORD_W-1:0] i_y_b,
    input  logic [mbde_pkg::RAD_W-1:0]          i_radius,
    // result channel
    output logic                                o_result_valid,
    output logic [mbde_pkg::DATA_W-1:0]         o_read_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbde_pkg::APB_AW-1:0]         paddr,
    input  logic [mbde_pkg::APB_DW-1:0]         pwdata,
    output logic [mbde_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int CFG_W = mbde_pkg::CFG_W;
    localparam int EWW   = $clog2(MAX_WIDTH + 1);
    localparam int EHW   = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0] r_page_width;
    logic [CFG_W-1:0] r_page_height;
    logic [EWW-1:0]   r_eff_w;
    logic [EHW-1:0]   r_eff_h;
    logic             cfg_wr;
    logic             reg_idx;

    mbde_pkg::t_queue_ctl   queue_ctl;
    mbde_pkg::t_entry       head;
    mbde_pkg::t_back_status back_status;
    logic                   pop;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_width  <= CFG_W'(512);
            r_page_height <= CFG_W'(512);
        end else if (cfg_wr) begin
            if (reg_idx == mbde_pkg::REG_PAGE_WIDTH) begin
                r_page_width <= pwdata[CFG_W-1:0];
            end else begin
                r_page_height <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (reg_idx)
            mbde_pkg::REG_PAGE_WIDTH:  prdata = mbde_pkg::APB_DW'(r_page_width);
            mbde_pkg::REG_PAGE_HEIGHT: prdata = mbde_pkg::APB_DW'(r_page_height);
            default:                   prdata = '0;
        endcase
    end

    // page size in force: zero acts as one, oversize is clamped
    always_ff @(posedge i_clk) begin
        if (r_page_width == '0)                     r_eff_w <= EWW'(1);
        else if (int'(r_page_width) > MAX_WIDTH)    r_eff_w <= EWW'(MAX_WIDTH);
        else                                        r_eff_w <= EWW'(r_page_width);

        if (r_page_height == '0)                    r_eff_h <= EHW'(1);
        else if (int'(r_page_height) > MAX_HEIGHT)  r_eff_h <= EHW'(MAX_HEIGHT);
        else                                        r_eff_h <= EHW'(r_page_height);
    end

    mbde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_req_type (i_req_type),
        .i_x_a      (i_x_a),
        .i_y_a      (i_y_a),
        .i_x_b      (i_x_b),
        .i_y_b      (i_y_b),
        .i_radius   (i_radius),
        .i_status   (back_status),
        .i_pop      (pop),
        .o_ctl      (queue_ctl),
        .o_head     (head)
    );

    mbde_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_eff_w        (r_eff_w),
        .i_eff_h        (r_eff_h),
        .i_ctl          (queue_ctl),
        .i_head         (head),
        .o_pop          (pop),
        .o_status       (back_status),
        .o_result_valid (o_result_valid),
        .o_read_data    (o_read_data)
    );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives drawing commands into the bitmap engine over several page sizes,
// predicts every result with an in-bench pixel model and compares the
// eight-pixel reads in order. Page size is set over APB while idle.
// ----------------------------------------------------------------------------
module testbench;
    import mbde_pkg::*;

    localparam int         PIX_DEPTH   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam logic [2:0] ADDR_WIDTH  = 3'd4 * REG_PAGE_WIDTH;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4 * REG_PAGE_HEIGHT;
    localparam int         DRAIN_CYC   = 40;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [REQ_W-1:0]          i_req_type;
    logic signed [COORD_W-1:0] i_x_a, i_y_a, i_x_b, i_y_b;
    logic [RAD_W-1:0]          i_radius;
    logic                      o_result_valid;
    logic [DATA_W-1:0]         o_read_data;
    logic                      psel, penable, pwrite;
    logic [APB_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    monochrome_bitmap_draw_engine_core dut (.*);

    // 4 time unit clock
    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // ---------------------------------------------------------------- model
    // Pixels are kept linear (y*width+x), so a page resize reinterprets the
    // stored bits exactly as the hardware RAM does.
    bit                pixel_mem [PIX_DEPTH];
    logic [CFG_W-1:0]  reg_width, reg_height;
    logic [DATA_W-1:0] expected_reads [$];
    int                errors;
    bit                allow_idle;

    function automatic int page_w();
        if (reg_width == 0) return 1;
        if (reg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(reg_width);
    endfunction

    function automatic int page_h();
        if (reg_height == 0) return 1;
        if (reg_height > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
        return int'(reg_height);
    endfunction

    function automatic bit on_page(int x, int y);
        return x >= 0 && y >= 0 && x < page_w() && y < page_h();
    endfunction

    function automatic void set_px(int x, int y);
        if (on_page(x, y)) pixel_mem[y * page_w() + x] = 1'b1;
    endfunction

    function automatic void set_quad(int cx, int cy, int x, int y);
        set_px(cx + x, cy - y);
        set_px(cx - x, cy - y);
        set_px(cx + x, cy + y);
        set_px(cx - x, cy + y);
    endfunction

    function automatic void set_run(int y, int xl, int xr);
        if (y < 0 || y >= page_h()) return;
        if (xl < 0) xl = 0;
        if (xr > page_w() - 1) xr = page_w() - 1;
        for (int x = xl; x <= xr; x++) pixel_mem[y * page_w() + x] = 1'b1;
    endfunction

    function automatic void draw_line(int x1, int y1, int x2, int y2);
        int dx, dy, dmaj, dmin, stp, t, off;
        bit ymaj;
        dx = x2 - x1;
        dy = y2 - y1;
        ymaj = ((dx < 0) ? -dx : dx) < ((dy < 0) ? -dy : dy);
        dmaj = ymaj ? dy : dx;
        dmin = ymaj ? dx : dy;
        stp = (dmaj < 0) ? -1 : 1;
        t = 0;
        forever begin
            off = (dmaj != 0) ? int'((longint'(t) * dmin) / dmaj) : 0;
            if (ymaj) set_px(x1 + off, y1 + t);
            else      set_px(x1 + t, y1 + off);
            if (t == dmaj) break;
            t += stp;
        end
    endfunction

    function automatic void draw_disc(int cx, int cy, int r);
        longint rr, xm, lim;
        rr = longint'(r) * r;
        xm = r;
        for (int y = 0; y <= r; y++) begin
            lim = rr - longint'(y) * y;
            while (xm >= 0 && xm * xm > lim) xm--;
            set_run(cy - y, cx - int'(xm), cx + int'(xm));
            set_run(cy + y, cx - int'(xm), cx + int'(xm));
        end
    endfunction

    function automatic void draw_ring(int cx, int cy, int r);
        longint rr, x, lim;
        rr = longint'(r) * r;
        x = 0;
        for (int y = r; y >= 0; y--) begin
            lim = rr - longint'(y) * y;
            forever begin
                set_quad(cx, cy, int'(x), y);
                if (x * x < lim) x++;
                else break;
            end
        end
    endfunction

    // applies one command to the pixel model, returns the expected read_data
    function automatic logic [DATA_W-1:0] draw_command(t_cmd cmd, int xa, int ya,
                                                       int xb, int yb, int r);
        logic [DATA_W-1:0] v;
        v = '0;
        case (cmd)
            CMD_CLEAR:  for (int i = 0; i < page_w() * page_h(); i++) pixel_mem[i] = 1'b0;
            CMD_POINT:  set_px(xa, ya);
            CMD_RECT: begin
                if (xa < 0) xa = 0;
                if (ya < 0) ya = 0;
                if (xb > page_w()) xb = page_w();
                if (yb > page_h()) yb = page_h();
                for (int y = ya; y < yb; y++) set_run(y, xa, xb - 1);
            end
            CMD_LINE:   draw_line(xa, ya, xb, yb);
            CMD_DISC:   draw_disc(xa, ya, r);
            CMD_CIRCLE: draw_ring(xa, ya, r);
            CMD_READ: begin
                for (int k = 0; k < 8; k++)
                    if (on_page(xa + k, ya) && pixel_mem[ya * page_w() + xa + k])
                        v[7 - k] = 1'b1;
            end
            default: ;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------- helpers
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic idle_gap();
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // send one item, wait for acceptance, then update the model
    task automatic send_item(input t_cmd cmd, input int xa, input int ya,
                             input int xb, input int yb, input int r);
        logic signed [COORD_W-1:0] sxa, sya, sxb, syb;
        sxa = xa; sya = ya; sxb = xb; syb = yb;
        i_req_type <= cmd;
        i_x_a      <= sxa;
        i_y_a      <= sya;
        i_x_b      <= sxb;
        i_y_b      <= syb;
        i_radius   <= r[RAD_W-1:0];
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        expected_reads.push_back(draw_command(cmd, int'(sxa), int'(sya), int'(sxb),
                                              int'(syb), int'(r[RAD_W-1:0])));
        idle_gap();
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_reads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= addr; pwdata <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== val)
            report_error($sformatf("reg 0x%0h reads %0h, wrote %0h", addr, prdata, val));
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_page(input int w, input int h);
        wait_idle();
        apb_write(ADDR_WIDTH, CFG_W'(w));
        apb_write(ADDR_HEIGHT, CFG_W'(h));
        reg_width  = CFG_W'(w);
        reg_height = CFG_W'(h);
    endtask

    // coordinate near the page, now and then anywhere in the 15-bit range
    function automatic int pick_coord(int lim);
        logic signed [COORD_W-1:0] c;
        if ($urandom_range(0, 99) == 0) begin
            c = $urandom_range(0, 32767);
            return int'(c);
        end
        return int'($urandom_range(0, lim + 24)) - 12;
    endfunction

    task automatic random_items(input int n, input bit with_clear);
        t_cmd cmd;
        int   sel, r, w, h;
        for (int i = 0; i < n; i++) begin
            w = page_w();
            h = page_h();
            sel = $urandom_range(0, 99);
            if (sel < 2)       cmd = with_clear ? CMD_CLEAR : CMD_NOP;
            else if (sel < 12) cmd = CMD_POINT;
            else if (sel < 24) cmd = CMD_RECT;
            else if (sel < 38) cmd = CMD_LINE;
            else if (sel < 46) cmd = CMD_DISC;
            else if (sel < 54) cmd = CMD_CIRCLE;
            else if (sel < 56) cmd = CMD_NOP;
            else               cmd = CMD_READ;
            r = $urandom_range(0, 24);
            // a rare huge disc exercises the top radius bits
            if (cmd == CMD_DISC && $urandom_range(0, 49) == 0)
                r = $urandom_range(0, 16383);
            send_item(cmd, pick_coord(w), pick_coord(h), pick_coord(w), pick_coord(h), r);
        end
    endtask

    // --------------------------------------------------------------- tests
    task automatic test_default_page();
        send_item(CMD_POINT, 0, 0, 0, 0, 0);
        send_item(CMD_POINT, 511, 511, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 0, 0, 0);
        send_item(CMD_READ, 504, 511, 0, 0, 0);
        send_item(CMD_READ, 508, 511, 0, 0, 0);
        // extreme coordinates: whole-range line and huge shapes mostly off page
        send_item(CMD_LINE, -16384, -16384, 16383, 16383, 0);
        send_item(CMD_DISC, -16384, 16383, 0, 0, 16383);
        send_item(CMD_CIRCLE, 256, 256, 0, 0, 16383);
        send_item(CMD_RECT, -16384, -16384, 16383, 3, 0);
        send_item(CMD_READ, 0, 2, 0, 0, 0);
        send_item(CMD_READ, -4, 0, 0, 0, 0);
        send_item(CMD_READ, 16383, 16383, 0, 0, 0);
    endtask

    task automatic test_directed_small();
        set_page(64, 48);
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 0, 0, 0);
        send_item(CMD_POINT, 64, 10, 0, 0, 0);     // just off the right edge
        send_item(CMD_POINT, -1, 10, 0, 0, 0);
        send_item(CMD_RECT, 10, 5, 10, 9, 0);      // empty rectangle
        send_item(CMD_RECT, 60, 40, 70, 50, 0);    // clipped corner
        send_item(CMD_LINE, 3, 3, 3, 3, 0);        // zero length
        send_item(CMD_LINE, 20, 30, 5, 2, 0);      // y major, negative
        send_item(CMD_LINE, 5, 20, 40, 13, 0);     // x major
        send_item(CMD_DISC, 30, 24, 0, 0, 0);
        send_item(CMD_DISC, 2, 2, 0, 0, 7);
        send_item(CMD_CIRCLE, 40, 20, 0, 0, 9);
        send_item(CMD_CIRCLE, 10, 40, 0, 0, 0);
        send_item(CMD_NOP, 5, 5, 9, 9, 3);
        send_item(CMD_READ, 58, 40, 0, 0, 0);
        send_item(CMD_READ, 0, 2, 0, 0, 0);
        send_item(CMD_READ, 36, 20, 0, 0, 0);
        send_item(CMD_READ, 62, 47, 0, 0, 0);
    endtask

    task automatic test_random_mid();
        random_items(200, 1'b1);
    endtask

    task automatic test_tiny_pages();
        set_page(1, 1);
        random_items(50, 1'b1);
        set_page(0, 0);                            // zero acts as one
        random_items(30, 1'b1);
    endtask

    task automatic test_wide_short();
        set_page(1023, 7);                         // oversize width acts as max
        random_items(80, 1'b1);
        set_page(512, 3);
        random_items(40, 1'b1);
    endtask

    task automatic test_no_idle();
        set_page(23, 100);
        allow_idle = 1'b0;
        random_items(160, 1'b1);
    endtask

    // --------------------------------------------------------- result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_reads.size() == 0) begin
                report_error("result with nothing expected");
            end else begin
                if (o_read_data !== expected_reads[0])
                    report_error($sformatf("read_data %02h, expected %02h",
                                           o_read_data, expected_reads[0]));
                void'(expected_reads.pop_front());
            end
        end
    end

    initial begin
        errors = 0;
        allow_idle = 1'b1;
        reg_width = CFG_W'(MAX_WIDTH_DEF);
        reg_height = CFG_W'(MAX_HEIGHT_DEF);
        foreach (pixel_mem[i]) pixel_mem[i] = 1'b0;
        i_rst_n = 1'b0; start = 1'b0;
        i_req_type = '0; i_x_a = '0; i_y_a = '0; i_x_b = '0; i_y_b = '0; i_radius = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // clearing pass after reset holds busy high
        while (busy) @(posedge i_clk);
        test_default_page();
        test_directed_small();
        test_random_mid();
        test_tiny_pages();
        test_wide_short();
        test_no_idle();
        wait_idle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
